FILE: rtl/rlb_pkg.sv
package rlb_pkg;

    localparam int CH_W      = 8;
    localparam int NUM_LANES = 3;

    // 2*255*255 + 127 fits in 17 bits
    localparam int PROD_W = 17;

    // q = (y * RECIP) >> RECIP_SHIFT is exact y/255 for y < 2^17
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(131587);
    localparam logic [PROD_W-1:0]  ROUND_BIAS = PROD_W'(127);

    localparam logic [1:0] MODE_MULTIPLY = 2'd0;
    localparam logic [1:0] MODE_SUBTRACT = 2'd1;
    localparam logic [1:0] MODE_SCREEN   = 2'd2;
    localparam logic [1:0] MODE_OVERLAY  = 2'd3;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } pipe_ctl_t;

endpackage

FILE: rtl/rlb_lane.sv
module rlb_lane import rlb_pkg::*; (
    input  logic            aclk,
    input  pipe_ctl_t       ctl,
    input  logic [1:0]      mode,
    input  logic [CH_W-1:0] top_ch,
    input  logic [CH_W-1:0] bottom_ch,
    output logic [CH_W-1:0] result
);

    // stage 1: one 8x8 product on plain or complemented operands
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              inv_reg, inv_next;
    logic              sub_reg, sub_next;
    logic [CH_W-1:0]   diff_reg, diff_next;

    logic              use_comp;
    logic [CH_W-1:0]   op_a, op_b;
    logic [2*CH_W-1:0] mul;

    always_comb begin
        use_comp  = (mode == MODE_SCREEN) || ((mode == MODE_OVERLAY) && bottom_ch[CH_W-1]);
        op_a      = use_comp ? ~top_ch : top_ch;
        op_b      = use_comp ? ~bottom_ch : bottom_ch;
        mul       = op_a * op_b;
        prod_next = (mode == MODE_OVERLAY) ? {mul, 1'b0} : {1'b0, mul};
        inv_next  = use_comp;
        sub_next  = (mode == MODE_SUBTRACT);
        diff_next = (bottom_ch > top_ch) ? (bottom_ch - top_ch) : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctl.s1_load) begin
            prod_reg <= prod_next;
            inv_reg  <= inv_next;
            sub_reg  <= sub_next;
            diff_reg <= diff_next;
        end
    end

    // stage 2: rounded divide by 255 through the reciprocal
    localparam int WIDE_W = PROD_W + RECIP_W;

    logic [PROD_W-1:0] biased;
    logic [WIDE_W-1:0] wide;
    logic [CH_W-1:0]   quot;
    logic [CH_W-1:0]   res_reg, res_next;

    always_comb begin
        biased   = prod_reg + ROUND_BIAS;
        wide     = WIDE_W'(biased) * WIDE_W'(RECIP);
        quot     = wide[RECIP_SHIFT +: CH_W];
        if (sub_reg) begin
            res_next = diff_reg;
        end else if (inv_reg) begin
            res_next = ~quot;
        end else begin
            res_next = quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.s2_load) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

FILE: rtl/rlb_merge.sv
module rlb_merge import rlb_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [CH_W-1:0] lane_blue,
    input  logic [CH_W-1:0] lane_green,
    input  logic [CH_W-1:0] lane_red,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CH_W-1:0] m_out_blue,
    output logic [CH_W-1:0] m_out_green,
    output logic [CH_W-1:0] m_out_red
);

    logic                        valid_reg, valid_next;
    logic [NUM_LANES*CH_W-1:0]   word_reg;
    logic                        load;

    assign in_ready   = !valid_reg || m_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= {lane_red, lane_green, lane_blue};
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_blue  = word_reg[0 +: CH_W];
    assign m_out_green = word_reg[CH_W +: CH_W];
    assign m_out_red   = word_reg[2*CH_W +: CH_W];

endmodule

FILE: rtl/rgb_layer_blend_unit.sv
// channel | direction | handshake         | payload
// s_      | in        | s_valid / s_ready | s_top_{blue,green,red}, s_bottom_{blue,green,red}
// m_      | out       | m_valid / m_ready | m_out_{blue,green,red}
// cfg_    | in        | cfg_we            | cfg_wdata (blend mode)
//
// One pixel per cycle sustained while m_ready stays high; the pipeline holds a product
// stage, a reciprocal divide stage and an output register.
// Three lanes, one per color channel, run the same mode in parallel.
// Reset (aresetn low, synchronous) empties the pipeline and sets mode to multiply.
// A stalled output only blocks input once all three stages hold a word.
module rgb_layer_blend_unit import rlb_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [CH_W-1:0] s_top_blue,
    input  logic [CH_W-1:0] s_top_green,
    input  logic [CH_W-1:0] s_top_red,
    input  logic [CH_W-1:0] s_bottom_blue,
    input  logic [CH_W-1:0] s_bottom_green,
    input  logic [CH_W-1:0] s_bottom_red,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CH_W-1:0] m_out_blue,
    output logic [CH_W-1:0] m_out_green,
    output logic [CH_W-1:0] m_out_red
);

    logic [1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MULTIPLY;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    logic      v1_reg, v1_next;
    logic      v2_reg, v2_next;
    logic      merge_ready;
    logic      adv2;
    pipe_ctl_t ctl;

    always_comb begin
        adv2        = v2_reg && merge_ready;
        ctl.s2_load = v1_reg && (!v2_reg || merge_ready);
        s_ready     = !v1_reg || ctl.s2_load;
        ctl.s1_load = s_valid && s_ready;
        v1_next     = ctl.s1_load || (v1_reg && !ctl.s2_load);
        v2_next     = ctl.s2_load || (v2_reg && !adv2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    logic [CH_W-1:0] lane_blue, lane_green, lane_red;

    rlb_lane u_lane_blue (
        .aclk      (aclk),
        .ctl       (ctl),
        .mode      (mode_reg),
        .top_ch    (s_top_blue),
        .bottom_ch (s_bottom_blue),
        .result    (lane_blue)
    );

    rlb_lane u_lane_green (
        .aclk      (aclk),
        .ctl       (ctl),
        .mode      (mode_reg),
        .top_ch    (s_top_green),
        .bottom_ch (s_bottom_green),
        .result    (lane_green)
    );

    rlb_lane u_lane_red (
        .aclk      (aclk),
        .ctl       (ctl),
        .mode      (mode_reg),
        .top_ch    (s_top_red),
        .bottom_ch (s_bottom_red),
        .result    (lane_red)
    );

    rlb_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v2_reg),
        .in_ready    (merge_ready),
        .lane_blue   (lane_blue),
        .lane_green  (lane_green),
        .lane_red    (lane_red),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_blue  (m_out_blue),
        .m_out_green (m_out_green),
        .m_out_red   (m_out_red)
    );

endmodule

FILE: rtl/rlb_checker.sv
module rlb_checker import rlb_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input logic [CH_W-1:0] m_out_blue,
    input logic [CH_W-1:0] m_out_green,
    input logic [CH_W-1:0] m_out_red
);

    // words inside the block: accepted but not yet delivered
    logic [2:0] cnt_reg, cnt_next;
    logic       in_acc, out_acc;

    assign in_acc   = s_valid && s_ready;
    assign out_acc  = m_valid && m_ready;
    assign cnt_next = cnt_reg + 3'(in_acc) - 3'(out_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_blue)
            && $stable(m_out_green) && $stable(m_out_red))
        else $error("output word changed while stalled");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != 3'd0)
        else $error("output word without a matching input");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd3)
        else $error("more words in flight than pipeline stages");

    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < 3'd3 |-> s_ready)
        else $error("input blocked while a stage is free");

endmodule

bind rgb_layer_blend_unit rlb_checker u_rlb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_blue  (m_out_blue),
    .m_out_green (m_out_green),
    .m_out_red   (m_out_red)
);
